/* hw/rtl/idiv_pkg.sv */
// Shared types and constants for the 64-bit signed/unsigned integer divider.
// Holds the controller state encoding and the controller-to-datapath command bundle.
// No dependencies.
package idiv_pkg;

	// Width of every operand and result port.
	localparam int FIELD_W = 64;

	// Default arithmetic width of the divider.
	localparam int DEF_DATA_WIDTH = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture operands and form their magnitudes
		logic step;    // resolve one quotient bit
		logic finish;  // apply sign fix-up and write the result registers
	} cmd_t;

endpackage

/* hw/rtl/idiv_ctrl.sv */
// Controller state machine for the integer divider.
// Sequences load, iteration and finish and owns both handshakes; uses idiv_pkg.
module idiv_ctrl
	import idiv_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		// A waiting result leaves once the consumer takes it.
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CNT_W'(DATA_WIDTH - 1);
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_FINISH: begin
				// The result register must be free or freeing in this cycle.
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/idiv_dp.sv */
// Datapath of the integer divider: magnitude capture, restoring divide step, sign fix-up.
// Driven by command bits from idiv_ctrl; uses idiv_pkg.
module idiv_dp
	import idiv_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic [FIELD_W-1:0] dividend_bits,
	input  logic [FIELD_W-1:0] divisor_bits,
	input  logic               operation,
	output logic [FIELD_W-1:0] quotient_bits,
	output logic [FIELD_W-1:0] remainder_bits
);

	localparam int W = DATA_WIDTH;

	logic [W-1:0] num_q;   // remaining dividend bits, quotient shifts in from the bottom
	logic [W-1:0] den_q;
	logic [W-1:0] rem_q;
	logic         dvd_neg_q;
	logic         quo_neg_q;
	logic         zero_q;
	logic [FIELD_W-1:0] quo_out_q;
	logic [FIELD_W-1:0] rem_out_q;

	logic [W-1:0] a, b, mag_a, mag_b;
	logic         a_neg, b_neg;
	logic [W:0]   trial;
	logic         fits;
	logic [W-1:0] quo_fix, rem_fix;
	logic [FIELD_W-1:0] quo_ext, rem_ext;

	always_comb begin
		a     = dividend_bits[W-1:0];
		b     = divisor_bits[W-1:0];
		a_neg = operation & a[W-1];
		b_neg = operation & b[W-1];
		mag_a = a_neg ? (~a + 1'b1) : a;
		mag_b = b_neg ? (~b + 1'b1) : b;
	end

	// One restoring step: shift in the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, num_q[W-1]} - {1'b0, den_q};
		fits  = ~trial[W];
	end

	always_comb begin
		quo_fix = zero_q ? '0 : (quo_neg_q ? (~num_q + 1'b1) : num_q);
		rem_fix = zero_q ? '0 : (dvd_neg_q ? (~rem_q + 1'b1) : rem_q);
		quo_ext = '0;
		rem_ext = '0;
		quo_ext[W-1:0] = quo_fix;
		rem_ext[W-1:0] = rem_fix;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q     <= mag_a;
			den_q     <= mag_b;
			rem_q     <= '0;
			dvd_neg_q <= a_neg;
			quo_neg_q <= a_neg ^ b_neg;
			zero_q    <= (b == '0);
		end else if (cmd.step) begin
			num_q <= {num_q[W-2:0], fits};
			rem_q <= fits ? trial[W-1:0] : {rem_q[W-2:0], num_q[W-1]};
		end
		if (cmd.finish) begin
			quo_out_q <= quo_ext;
			rem_out_q <= rem_ext;
		end
	end

	assign quotient_bits  = quo_out_q;
	assign remainder_bits = rem_out_q;

endmodule

/* hw/rtl/int64_divider_signed_unsigned.sv */
// Top level of the signed/unsigned integer divider.
// Instantiates idiv_ctrl and idiv_dp; uses idiv_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in       to block   in_valid / in_stall  dividend_bits, divisor_bits, operation
//   out      from block out_valid / out_stall quotient_bits, remainder_bits
//
// An item passes through load, iteration and finish before the next can be accepted:
// the load captures the operand magnitudes, DATA_WIDTH iterations of the shared
// restoring subtract-and-shift step resolve one quotient bit per cycle, and the
// finish writes the sign fix-up into the output register. Reset clears the controller
// and the output valid flag only; no clearing pass is needed. in_stall stays high
// while an item is in work, and a result held by out_stall keeps the next item in
// its finish cycle until the output register frees.
module int64_divider_signed_unsigned
	import idiv_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FIELD_W-1:0] dividend_bits,
	input  logic [FIELD_W-1:0] divisor_bits,
	input  logic               operation,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] quotient_bits,
	output logic [FIELD_W-1:0] remainder_bits
);

	// Command bundle from the controller to the datapath.
	cmd_t cmd;

	// The controller counts the iterations and owns both handshakes.
	idiv_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	// The datapath holds operands, partial remainder, quotient and result registers.
	// Divide by zero yields zero for both results; signed mode divides magnitudes,
	// negates the quotient on differing signs and gives the remainder the dividend's sign.
	idiv_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.dividend_bits (dividend_bits),
		.divisor_bits  (divisor_bits),
		.operation     (operation),
		.quotient_bits (quotient_bits),
		.remainder_bits(remainder_bits)
	);

`ifndef SYNTHESIS
	// An accepted beat keeps the unit busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("divider accepted a beat but did not go busy");

	// A fresh result appears only as the unit returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result presented while the unit is still busy");

	// A beat accepted from idle cannot produce a result in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared too early after acceptance");
`endif

endmodule
